### rtl/core/dlts_pkg.sv
// shared types, codes and constants of the delta list timer scheduler
package dlts_pkg;

	localparam int POOL_SIZE_DEF = 16;
	localparam int ID_W = 8;
	localparam int TIME_W = 32;
	localparam int TICK_W = 16;
	localparam logic [TICK_W-1:0] TICK_RESET = 16'd10;
	localparam logic [ID_W-1:0] ID_FIRST = 8'd1;
	localparam logic [ID_W-1:0] ID_LAST = 8'd255;

	// command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DECODE,
		OP_TICK_UPD,
		OP_SET_TAKE,
		OP_CLR_TAKE,
		OP_CLR_FREE,
		OP_INS_START,
		OP_INS_CMP,
		OP_INS_DONE,
		OP_INS_LINK,
		OP_CHK_START,
		OP_CHK_USE,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_WAIT,
		ST_TICK_UPD,
		ST_DIV,
		ST_SET_TAKE,
		ST_CLR_WAIT,
		ST_CLR_TAKE,
		ST_CLR_FREE,
		ST_INS_START,
		ST_INS_WAIT,
		ST_INS_CMP,
		ST_INS_DONE,
		ST_INS_LINK,
		ST_CHK_START,
		ST_CHK_WAIT,
		ST_CHK_USE,
		ST_FINISH
	} state_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [1:0] cmd;
		logic head_nil;
		logic free_nil;
		logic cur_nil;
		logic null_req;
		logic cnt_ge;
		logic rd_per_zero;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/core/dlts_ram.sv
// generic single write port ram with registered read
module dlts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/dlts_datapath.sv
// datapath: list pointers, entry memories, divider, flag and output register
module dlts_datapath #(
	parameter int POOL_SIZE = dlts_pkg::POOL_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dlts_pkg::dp_op_t            op,
	output dlts_pkg::dp_status_t        status,
	input  logic [71:0]                 s_tdata,
	input  logic                        cfg_we,
	input  logic [dlts_pkg::TICK_W-1:0] cfg_wdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata
);

	localparam int IW = $clog2(POOL_SIZE + 1);
	localparam int AW = $clog2(POOL_SIZE);
	localparam logic [IW-1:0] NIL = IW'(POOL_SIZE);
	localparam int TW = dlts_pkg::TIME_W;
	localparam int KW = dlts_pkg::TICK_W;
	localparam int DW = dlts_pkg::ID_W;
	localparam int EW = TW + TW + DW;
	localparam int CW = $clog2(TW + 1);

	// control state
	logic [IW-1:0] head_q, free_q, cur_q;
	logic [DW-1:0] next_id_q, flag_q;
	logic [KW-1:0] tick_q;
	logic          out_valid_q;
	logic [CW-1:0] div_cnt_q;
	logic [POOL_SIZE-1:0] link_valid_q;

	// payload state
	logic [1:0]    cmd_q;
	logic [TW-1:0] delay_q, period_q;
	logic [IW-1:0] slot_q, prev_q;
	logic [TW-1:0] cnt_q, per_q;
	logic [DW-1:0] id_q, assigned_q;
	logic [KW-1:0] dv_q;
	logic [TW-1:0] dq_q, pq_q;
	logic [KW-1:0] dr_q, pr_q;
	logic [15:0]   out_data_q;
	logic [AW-1:0] lk_ra_q;

	// memory ports
	logic          ent_we, lk_we;
	logic [AW-1:0] ent_wa, lk_wa, rd_addr;
	logic [EW-1:0] ent_wd, ent_rd;
	logic [IW-1:0] lk_wd, lk_ram_rd, link_rd;
	logic [TW-1:0] rd_cnt, rd_per;
	logic [DW-1:0] rd_id;

	// divider step signals
	logic [KW:0]   d_rr, p_rr, d_rn, p_rn;
	logic          d_ge, p_ge;

	assign rd_addr = (cur_q == NIL) ? '0 : cur_q[AW-1:0];
	assign {rd_per, rd_cnt, rd_id} = ent_rd;

	dlts_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.raddr(rd_addr), .rdata(ent_rd)
	);

	dlts_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_link_ram (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
		.raddr(rd_addr), .rdata(lk_ram_rd)
	);

	// unwritten links read as the reset chain
	assign link_rd = link_valid_q[lk_ra_q] ? lk_ram_rd : (IW'(lk_ra_q) + IW'(1));

	// restoring divider steps for delay and period
	always_comb begin
		d_rr = {dr_q, dq_q[TW-1]};
		p_rr = {pr_q, pq_q[TW-1]};
		d_ge = d_rr >= {1'b0, dv_q};
		p_ge = p_rr >= {1'b0, dv_q};
		d_rn = d_ge ? (d_rr - {1'b0, dv_q}) : d_rr;
		p_rn = p_ge ? (p_rr - {1'b0, dv_q}) : p_rr;
	end

	// memory write selection
	always_comb begin
		ent_we = 1'b0;
		ent_wa = rd_addr;
		ent_wd = {rd_per, rd_cnt, rd_id};
		lk_we = 1'b0;
		lk_wa = slot_q[AW-1:0];
		lk_wd = cur_q;
		case (op)
			dlts_pkg::OP_TICK_UPD: begin
				ent_we = rd_cnt != '0;
				ent_wd = {rd_per, rd_cnt - TW'(1), rd_id};
			end
			dlts_pkg::OP_INS_CMP: begin
				ent_we = !(cnt_q >= rd_cnt);
				ent_wd = {rd_per, rd_cnt - cnt_q, rd_id};
			end
			dlts_pkg::OP_INS_DONE: begin
				ent_we = 1'b1;
				ent_wa = slot_q[AW-1:0];
				ent_wd = {per_q, cnt_q, id_q};
				lk_we = 1'b1;
			end
			dlts_pkg::OP_INS_LINK: begin
				lk_we = prev_q != NIL;
				lk_wa = prev_q[AW-1:0];
				lk_wd = slot_q;
			end
			dlts_pkg::OP_CLR_FREE: begin
				lk_we = 1'b1;
				lk_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			free_q <= '0;
			cur_q <= NIL;
			next_id_q <= dlts_pkg::ID_FIRST;
			flag_q <= '0;
			tick_q <= dlts_pkg::TICK_RESET;
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
			link_valid_q <= '0;
		end else begin
			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end
			if (lk_we) begin
				link_valid_q[lk_wa] <= 1'b1;
			end
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - CW'(1);
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				dlts_pkg::OP_DECODE: begin
					cur_q <= (cmd_q == dlts_pkg::CMD_SET) ? free_q : head_q;
					if (cmd_q == dlts_pkg::CMD_CLEAR) begin
						flag_q <= '0;
					end
					div_cnt_q <= CW'(TW);
				end
				dlts_pkg::OP_TICK_UPD: begin
					if (rd_cnt == TW'(1)) begin
						flag_q <= rd_id;
					end
				end
				dlts_pkg::OP_SET_TAKE: begin
					free_q <= link_rd;
					next_id_q <= (next_id_q >= dlts_pkg::ID_LAST) ? dlts_pkg::ID_FIRST
						: next_id_q + DW'(1);
				end
				dlts_pkg::OP_CLR_TAKE: begin
					head_q <= link_rd;
				end
				dlts_pkg::OP_CLR_FREE: begin
					free_q <= slot_q;
				end
				dlts_pkg::OP_INS_START: begin
					cur_q <= head_q;
				end
				dlts_pkg::OP_INS_CMP: begin
					if (cnt_q >= rd_cnt) begin
						cur_q <= link_rd;
					end
				end
				dlts_pkg::OP_INS_LINK: begin
					if (prev_q == NIL) begin
						head_q <= slot_q;
					end
				end
				dlts_pkg::OP_CHK_START: begin
					cur_q <= head_q;
				end
				dlts_pkg::OP_CHK_USE: begin
					if (cur_q != NIL && rd_cnt == '0) begin
						flag_q <= rd_id;
					end
				end
				dlts_pkg::OP_FINISH: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lk_ra_q <= rd_addr;
		if (div_cnt_q != '0) begin
			dq_q <= {dq_q[TW-2:0], d_ge};
			pq_q <= {pq_q[TW-2:0], p_ge};
			dr_q <= d_rn[KW-1:0];
			pr_q <= p_rn[KW-1:0];
		end
		case (op)
			dlts_pkg::OP_ACCEPT: begin
				cmd_q <= s_tdata[1:0];
				delay_q <= s_tdata[33:2];
				period_q <= s_tdata[65:34];
			end
			dlts_pkg::OP_DECODE: begin
				assigned_q <= '0;
				dv_q <= (tick_q == '0) ? KW'(1) : tick_q;
				dq_q <= delay_q;
				pq_q <= period_q;
				dr_q <= '0;
				pr_q <= '0;
			end
			dlts_pkg::OP_SET_TAKE: begin
				slot_q <= cur_q;
				id_q <= next_id_q;
				assigned_q <= next_id_q;
				cnt_q <= dq_q;
				per_q <= pq_q;
			end
			dlts_pkg::OP_CLR_TAKE: begin
				slot_q <= cur_q;
				id_q <= rd_id;
				cnt_q <= rd_per;
				per_q <= rd_per;
			end
			dlts_pkg::OP_INS_START: begin
				prev_q <= NIL;
			end
			dlts_pkg::OP_INS_CMP: begin
				if (cnt_q >= rd_cnt) begin
					cnt_q <= cnt_q - rd_cnt;
					prev_q <= cur_q;
				end
			end
			dlts_pkg::OP_FINISH: begin
				out_data_q <= {flag_q, assigned_q};
			end
			default: begin
			end
		endcase
	end

	// status toward the controller
	always_comb begin
		status.cmd = cmd_q;
		status.head_nil = head_q == NIL;
		status.free_nil = free_q == NIL;
		status.cur_nil = cur_q == NIL;
		status.null_req = (delay_q == '0) && (period_q == '0);
		status.cnt_ge = cnt_q >= rd_cnt;
		status.rd_per_zero = rd_per == '0;
		status.div_done = div_cnt_q == '0;
		status.out_free = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

`ifndef NO_ASSERTIONS
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= NIL) else $error("cursor beyond pool");
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0) else $error("id counter reached zero");
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		op == dlts_pkg::OP_DECODE |=> div_cnt_q == CW'(TW)) else $error("divider not started");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		op == dlts_pkg::OP_FINISH |=> out_valid_q) else $error("result not posted");
`endif

endmodule

### rtl/core/dlts_ctrl.sv
// controller state machine sequencing tick, set, clear and list insertion
module dlts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  dlts_pkg::dp_status_t status,
	output dlts_pkg::dp_op_t     op
);

	dlts_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlts_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = dlts_pkg::ST_DECODE;
			end
			dlts_pkg::ST_DECODE: begin
				case (status.cmd)
					dlts_pkg::CMD_TICK: state_d = status.head_nil ? dlts_pkg::ST_FINISH
						: dlts_pkg::ST_TICK_WAIT;
					dlts_pkg::CMD_SET: state_d = (status.null_req || status.free_nil)
						? dlts_pkg::ST_FINISH : dlts_pkg::ST_DIV;
					dlts_pkg::CMD_CLEAR: state_d = status.head_nil ? dlts_pkg::ST_FINISH
						: dlts_pkg::ST_CLR_WAIT;
					default: state_d = dlts_pkg::ST_FINISH;
				endcase
			end
			dlts_pkg::ST_TICK_WAIT: state_d = dlts_pkg::ST_TICK_UPD;
			dlts_pkg::ST_TICK_UPD: state_d = dlts_pkg::ST_FINISH;
			dlts_pkg::ST_DIV: begin
				if (status.div_done) state_d = dlts_pkg::ST_SET_TAKE;
			end
			dlts_pkg::ST_SET_TAKE: state_d = dlts_pkg::ST_INS_START;
			dlts_pkg::ST_CLR_WAIT: state_d = dlts_pkg::ST_CLR_TAKE;
			dlts_pkg::ST_CLR_TAKE: state_d = status.rd_per_zero ? dlts_pkg::ST_CLR_FREE
				: dlts_pkg::ST_INS_START;
			dlts_pkg::ST_CLR_FREE: state_d = dlts_pkg::ST_CHK_START;
			dlts_pkg::ST_INS_START: state_d = dlts_pkg::ST_INS_WAIT;
			dlts_pkg::ST_INS_WAIT: state_d = status.cur_nil ? dlts_pkg::ST_INS_DONE
				: dlts_pkg::ST_INS_CMP;
			dlts_pkg::ST_INS_CMP: state_d = status.cnt_ge ? dlts_pkg::ST_INS_WAIT
				: dlts_pkg::ST_INS_DONE;
			dlts_pkg::ST_INS_DONE: state_d = dlts_pkg::ST_INS_LINK;
			dlts_pkg::ST_INS_LINK: state_d = dlts_pkg::ST_CHK_START;
			dlts_pkg::ST_CHK_START: state_d = dlts_pkg::ST_CHK_WAIT;
			dlts_pkg::ST_CHK_WAIT: state_d = dlts_pkg::ST_CHK_USE;
			dlts_pkg::ST_CHK_USE: state_d = dlts_pkg::ST_FINISH;
			dlts_pkg::ST_FINISH: begin
				if (status.out_free) state_d = dlts_pkg::ST_IDLE;
			end
			default: state_d = dlts_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		op = dlts_pkg::OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			dlts_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) op = dlts_pkg::OP_ACCEPT;
			end
			dlts_pkg::ST_DECODE: op = dlts_pkg::OP_DECODE;
			dlts_pkg::ST_TICK_UPD: op = dlts_pkg::OP_TICK_UPD;
			dlts_pkg::ST_SET_TAKE: op = dlts_pkg::OP_SET_TAKE;
			dlts_pkg::ST_CLR_TAKE: op = dlts_pkg::OP_CLR_TAKE;
			dlts_pkg::ST_CLR_FREE: op = dlts_pkg::OP_CLR_FREE;
			dlts_pkg::ST_INS_START: op = dlts_pkg::OP_INS_START;
			dlts_pkg::ST_INS_CMP: op = dlts_pkg::OP_INS_CMP;
			dlts_pkg::ST_INS_DONE: op = dlts_pkg::OP_INS_DONE;
			dlts_pkg::ST_INS_LINK: op = dlts_pkg::OP_INS_LINK;
			dlts_pkg::ST_CHK_START: op = dlts_pkg::OP_CHK_START;
			dlts_pkg::ST_CHK_USE: op = dlts_pkg::OP_CHK_USE;
			dlts_pkg::ST_FINISH: begin
				if (status.out_free) op = dlts_pkg::OP_FINISH;
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == dlts_pkg::ST_IDLE) else $error("ready outside idle");
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == dlts_pkg::ST_DECODE) else $error("transfer lost");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dlts_pkg::ST_SET_TAKE |-> status.div_done) else $error("quotient not ready");
`endif

endmodule

### rtl/core/delta_list_timer_scheduler.sv
// top level of the delta list timer scheduler
// Timer pool kept as a delta list, one command per input transfer and one result per command.
// Items are handled one at a time; the result sits in an output register so the next
// command is taken while it waits, and a command that finishes while the previous result
// is still held waits for that transfer. A tick on an empty list only posts a result. A set
// either fails or runs a 32-step restoring divider (delay and period in parallel) and then
// walks the list to insert the new entry. A clear reinserts the head by the same walk when
// the head is reloaded, frees it otherwise and only posts a result on an empty list. The
// list walk reads each entry through the registered read of the entry memories.
// No clearing pass runs after reset.
module delta_list_timer_scheduler #(
	parameter int POOL_SIZE = dlts_pkg::POOL_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [71:0]                 s_tdata,   // cmd[1:0], delay_ms[33:2], period_ms[65:34]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // assigned_id[7:0], flag_id[15:8]
	input  logic                        cfg_we,
	input  logic [dlts_pkg::TICK_W-1:0] cfg_wdata  // tick_period_ms
);

	dlts_pkg::dp_op_t     op;
	dlts_pkg::dp_status_t status;

	// sequencing
	dlts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.status(status), .op(op)
	);

	// storage and arithmetic
	dlts_datapath #(.POOL_SIZE(POOL_SIZE)) u_datapath (
		.clk(clk), .arst_n(arst_n), .op(op), .status(status), .s_tdata(s_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
